>>> hdl/etrt_pkg.sv
package etrt_pkg;

   localparam int RULE_SLOTS = 4;
   localparam int SLOT_W     = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
   localparam int SCAN_W     = $clog2(RULE_SLOTS + 1);
   localparam int MAX_FIRES  = 4;
   localparam int FIRE_W     = $clog2(MAX_FIRES + 1);

   typedef enum logic [1:0] {
      OP_ADD     = 2'd0,
      OP_REMOVE  = 2'd1,
      OP_READ    = 2'd2,
      OP_READING = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_BAD_SENSOR = 3'd1,
      ST_BAD_TARGET = 3'd2,
      ST_NOT_SWITCH = 3'd3,
      ST_NO_SLOT    = 3'd4,
      ST_BAD_INDEX  = 3'd5,
      ST_NOT_ACTIVE = 3'd6
   } status_type;

   typedef enum logic [1:0] {
      KIND_UNKNOWN = 2'd0,
      KIND_LIGHT   = 2'd1,
      KIND_RELAY   = 2'd2,
      KIND_OTHER   = 2'd3
   } kind_type;

   typedef struct packed {
      op_type      operation;
      logic [7:0]  sensor_dev;
      logic [7:0]  target_id;
      logic        sensor_is_sensor;
      kind_type    target_kind;
      logic        trigger_level;
      logic        action_level;
      logic [3:0]  rule_index;
      logic        reading_valid;
      logic [15:0] sensor_value;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [3:0]  slot;
      logic        fire;
      logic [7:0]  out_target;
      logic        out_level;
      logic        out_active;
      logic [7:0]  out_sensor;
      logic        out_trigger;
      logic        out_fired;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic accept_en;
      logic exec;
      logic scan_step;
      logic flush;
   } cmd_type;

   typedef struct packed {
      logic req_take;
      logic req_scan;
      logic scan_done;
      logic scan_hit;
      logic pend_vld;
      logic out_free;
   } stat_type;

endpackage

>>> hdl/etrt_if.sv
interface etrt_req_if;
   import etrt_pkg::*;

   logic        valid;
   logic        ready;
   op_type      operation;
   logic [7:0]  sensor_dev;
   logic [7:0]  target_id;
   logic        sensor_is_sensor;
   kind_type    target_kind;
   logic        trigger_level;
   logic        action_level;
   logic [3:0]  rule_index;
   logic        reading_valid;
   logic [15:0] sensor_value;

   modport source (
      output valid, operation, sensor_dev, target_id, sensor_is_sensor, target_kind,
             trigger_level, action_level, rule_index, reading_valid, sensor_value,
      input  ready
   );

   modport sink (
      input  valid, operation, sensor_dev, target_id, sensor_is_sensor, target_kind,
             trigger_level, action_level, rule_index, reading_valid, sensor_value,
      output ready
   );
endinterface

interface etrt_rsp_if;
   import etrt_pkg::*;

   logic       valid;
   logic       ready;
   status_type status;
   logic [3:0] slot;
   logic       fire;
   logic [7:0] out_target;
   logic       out_level;
   logic       out_active;
   logic [7:0] out_sensor;
   logic       out_trigger;
   logic       out_fired;
   logic       last;

   modport source (
      output valid, status, slot, fire, out_target, out_level, out_active,
             out_sensor, out_trigger, out_fired, last,
      input  ready
   );

   modport sink (
      input  valid, status, slot, fire, out_target, out_level, out_active,
             out_sensor, out_trigger, out_fired, last,
      output ready
   );
endinterface

>>> hdl/etrt_ctrl.sv
module etrt_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  etrt_pkg::stat_type stat,
   output etrt_pkg::cmd_type  cmd
);
   import etrt_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_SCAN,
      S_FLUSH
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            cmd.accept_en = 1'b1;
            if (stat.req_take) begin
               state_in = stat.req_scan ? S_SCAN : S_EXEC;
            end
         end
         S_EXEC: begin
            if (stat.out_free) begin
               cmd.exec = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_SCAN: begin
            if (stat.scan_done) begin
               state_in = S_FLUSH;
            end else if (!(stat.scan_hit && stat.pend_vld && !stat.out_free)) begin
               cmd.scan_step = 1'b1;
            end
         end
         S_FLUSH: begin
            if (stat.out_free) begin
               cmd.flush = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> hdl/etrt_datapath.sv
module etrt_datapath (
   input  logic               clock,
   input  logic               reset,
   etrt_req_if.sink           req_chan,
   etrt_rsp_if.source         rsp_chan,
   input  etrt_pkg::cmd_type  cmd,
   output etrt_pkg::stat_type stat
);
   import etrt_pkg::*;

   logic             active_ff  [RULE_SLOTS];
   logic [7:0]       sensor_ff  [RULE_SLOTS];
   logic [7:0]       target_ff  [RULE_SLOTS];
   logic             trigger_ff [RULE_SLOTS];
   logic             action_ff  [RULE_SLOTS];
   logic             fired_ff   [RULE_SLOTS];

   req_type          item_ff;
   req_type          req_in;
   rsp_type          rsp_ff;
   rsp_type          rsp_in;
   rsp_type          pend_ff;
   logic             rsp_vld_ff;
   logic             pend_vld_ff;
   logic [SCAN_W-1:0] idx_ff;
   logic [FIRE_W-1:0] nfire_ff;

   logic              req_take;
   logic              out_free;
   logic              load_out;
   logic              free_any;
   logic [SLOT_W-1:0] free_idx;
   logic              idx_ok;
   logic [SLOT_W-1:0] ridx;
   logic              add_ok;
   logic              rm_ok;
   rsp_type           single;
   rsp_type           fire_rsp;
   rsp_type           flush_rsp;
   logic [SLOT_W-1:0] cur;
   logic              scan_done;
   logic              cur_match;
   logic              cur_eq;
   logic              hit;
   logic              rearm;

   always_comb begin
      req_in.operation        = req_chan.operation;
      req_in.sensor_dev       = req_chan.sensor_dev;
      req_in.target_id        = req_chan.target_id;
      req_in.sensor_is_sensor = req_chan.sensor_is_sensor;
      req_in.target_kind      = req_chan.target_kind;
      req_in.trigger_level    = req_chan.trigger_level;
      req_in.action_level     = req_chan.action_level;
      req_in.rule_index       = req_chan.rule_index;
      req_in.reading_valid    = req_chan.reading_valid;
      req_in.sensor_value     = req_chan.sensor_value;
   end

   assign req_chan.ready = cmd.accept_en;
   assign req_take       = req_chan.valid && cmd.accept_en;
   assign out_free       = !rsp_vld_ff || rsp_chan.ready;

   always_comb begin
      free_any = 1'b0;
      free_idx = '0;
      for (int i = RULE_SLOTS - 1; i >= 0; i--) begin
         if (!active_ff[i]) begin
            free_any = 1'b1;
            free_idx = SLOT_W'(i);
         end
      end
   end

   assign idx_ok = {1'b0, item_ff.rule_index} < 5'(RULE_SLOTS);
   assign ridx   = item_ff.rule_index[SLOT_W-1:0];

   always_comb begin
      single      = '0;
      single.last = 1'b1;
      add_ok      = 1'b0;
      rm_ok       = 1'b0;
      case (item_ff.operation)
         OP_ADD: begin
            if (!item_ff.sensor_is_sensor) begin
               single.status = ST_BAD_SENSOR;
            end else if (item_ff.target_kind == KIND_UNKNOWN) begin
               single.status = ST_BAD_TARGET;
            end else if (item_ff.target_kind == KIND_OTHER) begin
               single.status = ST_NOT_SWITCH;
            end else if (!free_any) begin
               single.status = ST_NO_SLOT;
            end else begin
               add_ok      = 1'b1;
               single.slot = 4'(free_idx);
            end
         end
         OP_REMOVE: begin
            if (!idx_ok) begin
               single.status = ST_BAD_INDEX;
            end else if (!active_ff[ridx]) begin
               single.status = ST_NOT_ACTIVE;
               single.slot   = 4'(ridx);
            end else begin
               rm_ok       = 1'b1;
               single.slot = 4'(ridx);
            end
         end
         OP_READ: begin
            if (!idx_ok) begin
               single.status = ST_BAD_INDEX;
            end else begin
               single.slot        = 4'(ridx);
               single.out_target  = target_ff[ridx];
               single.out_level   = action_ff[ridx];
               single.out_active  = active_ff[ridx];
               single.out_sensor  = sensor_ff[ridx];
               single.out_trigger = trigger_ff[ridx];
               single.out_fired   = fired_ff[ridx];
            end
         end
         default: begin
         end
      endcase
   end

   assign cur       = idx_ff[SLOT_W-1:0];
   assign scan_done = idx_ff == SCAN_W'(RULE_SLOTS);
   assign cur_match = !scan_done && active_ff[cur] && (sensor_ff[cur] == item_ff.sensor_dev);
   assign cur_eq    = item_ff.sensor_value == {15'd0, trigger_ff[cur]};
   assign hit       = cur_match && cur_eq && !fired_ff[cur] && (nfire_ff < FIRE_W'(MAX_FIRES));
   assign rearm     = cur_match && !cur_eq;

   always_comb begin
      fire_rsp            = '0;
      fire_rsp.slot       = 4'(cur);
      fire_rsp.fire       = 1'b1;
      fire_rsp.out_target = target_ff[cur];
      fire_rsp.out_level  = action_ff[cur];
      flush_rsp           = pend_vld_ff ? pend_ff : '0;
      flush_rsp.last      = 1'b1;
   end

   assign load_out = cmd.exec || cmd.flush || (cmd.scan_step && hit && pend_vld_ff);

   always_comb begin
      if (cmd.exec) begin
         rsp_in = single;
      end else if (cmd.flush) begin
         rsp_in = flush_rsp;
      end else begin
         rsp_in = pend_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < RULE_SLOTS; i++) begin
            active_ff[i]  <= 1'b0;
            sensor_ff[i]  <= '0;
            target_ff[i]  <= '0;
            trigger_ff[i] <= 1'b0;
            action_ff[i]  <= 1'b0;
            fired_ff[i]   <= 1'b0;
         end
         rsp_vld_ff  <= 1'b0;
         pend_vld_ff <= 1'b0;
         idx_ff      <= '0;
         nfire_ff    <= '0;
      end else begin
         if (req_take) begin
            idx_ff      <= '0;
            nfire_ff    <= '0;
            pend_vld_ff <= 1'b0;
         end
         if (cmd.exec && add_ok) begin
            active_ff[free_idx]  <= 1'b1;
            sensor_ff[free_idx]  <= item_ff.sensor_dev;
            target_ff[free_idx]  <= item_ff.target_id;
            trigger_ff[free_idx] <= item_ff.trigger_level;
            action_ff[free_idx]  <= item_ff.action_level;
            fired_ff[free_idx]   <= 1'b0;
         end
         if (cmd.exec && rm_ok) begin
            active_ff[ridx] <= 1'b0;
         end
         if (cmd.scan_step) begin
            if (hit) begin
               fired_ff[cur] <= 1'b1;
               nfire_ff      <= nfire_ff + FIRE_W'(1);
               pend_vld_ff   <= 1'b1;
            end
            if (rearm) begin
               fired_ff[cur] <= 1'b0;
            end
            idx_ff <= idx_ff + SCAN_W'(1);
         end
         if (cmd.flush) begin
            pend_vld_ff <= 1'b0;
         end
         if (load_out) begin
            rsp_vld_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff <= req_in;
      end
      if (cmd.scan_step && hit) begin
         pend_ff <= fire_rsp;
      end
      if (load_out) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_chan.valid       = rsp_vld_ff;
   assign rsp_chan.status      = rsp_ff.status;
   assign rsp_chan.slot        = rsp_ff.slot;
   assign rsp_chan.fire        = rsp_ff.fire;
   assign rsp_chan.out_target  = rsp_ff.out_target;
   assign rsp_chan.out_level   = rsp_ff.out_level;
   assign rsp_chan.out_active  = rsp_ff.out_active;
   assign rsp_chan.out_sensor  = rsp_ff.out_sensor;
   assign rsp_chan.out_trigger = rsp_ff.out_trigger;
   assign rsp_chan.out_fired   = rsp_ff.out_fired;
   assign rsp_chan.last        = rsp_ff.last;

   always_comb begin
      stat.req_take  = req_take;
      stat.req_scan  = (req_chan.operation == OP_READING) && req_chan.reading_valid;
      stat.scan_done = scan_done;
      stat.scan_hit  = hit;
      stat.pend_vld  = pend_vld_ff;
      stat.out_free  = out_free;
   end

endmodule

>>> hdl/edge_triggered_event_rule_table_core.sv
// Add, remove, read and ignored readings: the item is registered, then its result once
// the result register is free. Valid readings: the scan sequencer visits one rule slot
// per cycle unless stalled; fire results leave one per cycle at most. A full result
// register stalls the scan on a hit with a fire result pending, until the sink takes
// it. No new item is taken before the last result is loaded. Reset (synchronous, active
// high) clears every rule slot to zero, empties the result register and resets to idle.
module edge_triggered_event_rule_table_core (
   input logic        clock,
   input logic        reset,
   etrt_req_if.sink   req_chan,
   etrt_rsp_if.source rsp_chan
);
   import etrt_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   etrt_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .cmd   (cmd)
   );

   etrt_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .cmd      (cmd),
      .stat     (stat)
   );

endmodule

>>> hdl/etrt_checker.sv
module etrt_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input etrt_pkg::status_type rsp_status,
   input logic [3:0]           rsp_slot,
   input logic                 rsp_fire,
   input logic                 rsp_out_active,
   input logic                 rsp_last
);
   import etrt_pkg::*;

   property p_rsp_hold;
      @(posedge clock) disable iff (reset)
         rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_slot) && $stable(rsp_last)
                                     && $stable(rsp_fire);
   endproperty
   a_rsp_hold: assert property (p_rsp_hold) else $error("rsp dropped while stalled");

   property p_one_at_a_time;
      @(posedge clock) disable iff (reset)
         req_valid && req_ready |=> !req_ready;
   endproperty
   a_one_at_a_time: assert property (p_one_at_a_time)
      else $error("req taken while busy");

   property p_fire_ok;
      @(posedge clock) disable iff (reset)
         rsp_valid && rsp_fire |-> rsp_status == ST_OK && !rsp_out_active;
   endproperty
   a_fire_ok: assert property (p_fire_ok) else $error("fire result malformed");

   property p_partial_is_fire;
      @(posedge clock) disable iff (reset)
         rsp_valid && !rsp_last |-> rsp_fire;
   endproperty
   a_partial_is_fire: assert property (p_partial_is_fire)
      else $error("non-final result without fire");

endmodule

bind edge_triggered_event_rule_table_core etrt_checker u_etrt_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_status     (rsp_chan.status),
   .rsp_slot       (rsp_chan.slot),
   .rsp_fire       (rsp_chan.fire),
   .rsp_out_active (rsp_chan.out_active),
   .rsp_last       (rsp_chan.last)
);

>>> bench/edge_triggered_event_rule_table_core_tb.sv
`timescale 1ns / 100ps

module edge_triggered_event_rule_table_core_tb;
   import etrt_pkg::*;

   localparam int  GAP_MAX      = 8;
   localparam int  HOLD_CYCLES  = 120;
   localparam int  BURST_ITEMS  = 24;
   localparam int  PHASE_ITEMS  = 80;
   localparam int  TAIL_CYCLES  = 20;
   localparam int  CYCLE_LIMIT  = 400000;
   localparam int  REPORT_LIMIT = 10;
   localparam logic [7:0] SENSOR_A = 8'h3C;
   localparam logic [7:0] SENSOR_B = 8'hC3;

   typedef struct packed {
      req_type item;
      logic    typed;
      rsp_type want;
   } plan_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   etrt_req_if req_chan ();
   etrt_rsp_if rsp_chan ();

   edge_triggered_event_rule_table_core u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   logic       rule_used    [RULE_SLOTS];
   logic [7:0] rule_sensor  [RULE_SLOTS];
   logic [7:0] rule_target  [RULE_SLOTS];
   logic       rule_trigger [RULE_SLOTS];
   logic       rule_action  [RULE_SLOTS];
   logic       rule_fired   [RULE_SLOTS];

   rsp_type  scan_out [MAX_FIRES];
   int       scan_count;
   rsp_type  due_outcomes [$];
   int       fail_count    = 0;
   bit       no_idle       = 0;
   bit       hold_request  = 0;
   int       burst_left    = 0;
   plan_type plan [$];

   task automatic run_rule_table(input req_type r);
      rsp_type           res;
      bit                placed;
      int                s;
      logic [SLOT_W-1:0] ix;
      res = '0;
      res.status = ST_OK;
      scan_count = 0;
      ix = r.rule_index[SLOT_W-1:0];
      case (r.operation)
         OP_ADD: begin
            if (!r.sensor_is_sensor) begin
               res.status = ST_BAD_SENSOR;
            end else if (r.target_kind == KIND_UNKNOWN) begin
               res.status = ST_BAD_TARGET;
            end else if (r.target_kind == KIND_OTHER) begin
               res.status = ST_NOT_SWITCH;
            end else begin
               res.status = ST_NO_SLOT;
               placed = 0;
               for (s = 0; s < RULE_SLOTS; s++) begin
                  if (!placed && !rule_used[s]) begin
                     rule_used[s]    = 1'b1;
                     rule_sensor[s]  = r.sensor_dev;
                     rule_target[s]  = r.target_id;
                     rule_trigger[s] = r.trigger_level;
                     rule_action[s]  = r.action_level;
                     rule_fired[s]   = 1'b0;
                     res.status      = ST_OK;
                     res.slot        = s[3:0];
                     placed          = 1;
                  end
               end
            end
            scan_out[0] = res;
            scan_count  = 1;
         end
         OP_REMOVE: begin
            if (r.rule_index >= RULE_SLOTS) begin
               res.status = ST_BAD_INDEX;
            end else if (!rule_used[ix]) begin
               res.status = ST_NOT_ACTIVE;
               res.slot   = r.rule_index;
            end else begin
               rule_used[ix] = 1'b0;
               res.slot = r.rule_index;
            end
            scan_out[0] = res;
            scan_count  = 1;
         end
         OP_READ: begin
            if (r.rule_index >= RULE_SLOTS) begin
               res.status = ST_BAD_INDEX;
            end else begin
               res.slot        = r.rule_index;
               res.out_target  = rule_target[ix];
               res.out_level   = rule_action[ix];
               res.out_active  = rule_used[ix];
               res.out_sensor  = rule_sensor[ix];
               res.out_trigger = rule_trigger[ix];
               res.out_fired   = rule_fired[ix];
            end
            scan_out[0] = res;
            scan_count  = 1;
         end
         OP_READING: begin
            if (r.reading_valid) begin
               for (s = 0; s < RULE_SLOTS; s++) begin
                  if (rule_used[s] && rule_sensor[s] == r.sensor_dev) begin
                     if (r.sensor_value == {15'd0, rule_trigger[s]}) begin
                        if (!rule_fired[s] && scan_count < MAX_FIRES) begin
                           res            = '0;
                           res.status     = ST_OK;
                           res.slot       = s[3:0];
                           res.fire       = 1'b1;
                           res.out_target = rule_target[s];
                           res.out_level  = rule_action[s];
                           scan_out[scan_count] = res;
                           scan_count++;
                           rule_fired[s] = 1'b1;
                        end
                     end else begin
                        rule_fired[s] = 1'b0;
                     end
                  end
               end
            end
            if (scan_count == 0) begin
               res         = '0;
               res.status  = ST_OK;
               scan_out[0] = res;
               scan_count  = 1;
            end
         end
      endcase
      scan_out[scan_count - 1].last = 1'b1;
   endtask

   function automatic req_type idx_req(input op_type op, input logic [3:0] idx);
      req_type r;
      r = '0;
      r.operation  = op;
      r.rule_index = idx;
      return r;
   endfunction

   function automatic req_type add_req(input logic [7:0] sen, input logic [7:0] tgt,
                                       input logic is_sen, input kind_type kind,
                                       input logic trig, input logic act);
      req_type r;
      r = '0;
      r.operation        = OP_ADD;
      r.sensor_dev       = sen;
      r.target_id        = tgt;
      r.sensor_is_sensor = is_sen;
      r.target_kind      = kind;
      r.trigger_level    = trig;
      r.action_level     = act;
      return r;
   endfunction

   function automatic req_type reading_req(input logic [7:0] sen, input logic vld,
                                           input logic [15:0] val);
      req_type r;
      r = '0;
      r.operation     = OP_READING;
      r.sensor_dev    = sen;
      r.reading_valid = vld;
      r.sensor_value  = val;
      return r;
   endfunction

   function automatic rsp_type want(input status_type st, input logic [3:0] slot);
      rsp_type w;
      w = '0;
      w.status = st;
      w.slot   = slot;
      w.last   = 1'b1;
      return w;
   endfunction

   function automatic plan_type row(input req_type r, input logic typed, input rsp_type w);
      plan_type p;
      p.item  = r;
      p.typed = typed;
      p.want  = w;
      return p;
   endfunction

   function automatic req_type rand_req();
      req_type r;
      int      pick;
      r = '0;
      pick = $urandom_range(0, 99);
      if (pick < 25)      r.operation = OP_ADD;
      else if (pick < 45) r.operation = OP_REMOVE;
      else if (pick < 60) r.operation = OP_READ;
      else                r.operation = OP_READING;
      if ($urandom_range(0, 9) < 8)
         r.sensor_dev = ($urandom_range(0, 1) != 0) ? SENSOR_A : SENSOR_B;
      else
         r.sensor_dev = 8'($urandom_range(0, 255));
      r.target_id        = 8'($urandom_range(0, 255));
      r.sensor_is_sensor = ($urandom_range(0, 9) != 0);
      pick = $urandom_range(0, 9);
      if (pick == 0)      r.target_kind = KIND_UNKNOWN;
      else if (pick == 1) r.target_kind = KIND_OTHER;
      else                r.target_kind = ($urandom_range(0, 1) != 0) ? KIND_LIGHT : KIND_RELAY;
      r.trigger_level = 1'($urandom_range(0, 1));
      r.action_level  = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 9) < 8)
         r.rule_index = 4'($urandom_range(0, RULE_SLOTS - 1));
      else
         r.rule_index = 4'($urandom_range(0, 15));
      r.reading_valid = ($urandom_range(0, 9) != 0);
      if ($urandom_range(0, 99) < 85)
         r.sensor_value = 16'($urandom_range(0, 1));
      else
         r.sensor_value = 16'($urandom_range(0, 65535));
      return r;
   endfunction

   task automatic put_req(input req_type r);
      req_chan.operation        <= r.operation;
      req_chan.sensor_dev       <= r.sensor_dev;
      req_chan.target_id        <= r.target_id;
      req_chan.sensor_is_sensor <= r.sensor_is_sensor;
      req_chan.target_kind      <= r.target_kind;
      req_chan.trigger_level    <= r.trigger_level;
      req_chan.action_level     <= r.action_level;
      req_chan.rule_index       <= r.rule_index;
      req_chan.reading_valid    <= r.reading_valid;
      req_chan.sensor_value     <= r.sensor_value;
   endtask

   task automatic send_item(input req_type r, input logic typed, input rsp_type w);
      int gap;
      int k;
      gap = (no_idle || burst_left > 0) ? 0 : $urandom_range(0, GAP_MAX);
      if (burst_left > 0) burst_left--;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      put_req(r);
      req_chan.valid <= 1'b1;
      do @(posedge clock); while (!req_chan.ready);
      run_rule_table(r);
      if (typed) begin
         due_outcomes.push_back(w);
      end else begin
         for (k = 0; k < scan_count; k++) due_outcomes.push_back(scan_out[k]);
      end
   endtask

   task automatic drain_wait();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (due_outcomes.size() != 0);
   endtask

   function automatic string show(input rsp_type x);
      return $sformatf("st=%0d slot=%0d fire=%b tgt=%h lvl=%b act=%b sen=%h trg=%b fired=%b last=%b",
                       x.status, x.slot, x.fire, x.out_target, x.out_level, x.out_active,
                       x.out_sensor, x.out_trigger, x.out_fired, x.last);
   endfunction

   task automatic check_outcome();
      rsp_type got;
      rsp_type w;
      string   bad;
      got.status      = rsp_chan.status;
      got.slot        = rsp_chan.slot;
      got.fire        = rsp_chan.fire;
      got.out_target  = rsp_chan.out_target;
      got.out_level   = rsp_chan.out_level;
      got.out_active  = rsp_chan.out_active;
      got.out_sensor  = rsp_chan.out_sensor;
      got.out_trigger = rsp_chan.out_trigger;
      got.out_fired   = rsp_chan.out_fired;
      got.last        = rsp_chan.last;
      if (due_outcomes.size() == 0) begin
         fail_count++;
         if (fail_count <= REPORT_LIMIT)
            $display("unexpected result: %s", show(got));
      end else begin
         w = due_outcomes.pop_front();
         bad = "";
         if (got.status      !== w.status)      bad = {bad, " status"};
         if (got.slot        !== w.slot)        bad = {bad, " slot"};
         if (got.fire        !== w.fire)        bad = {bad, " fire"};
         if (got.out_target  !== w.out_target)  bad = {bad, " out_target"};
         if (got.out_level   !== w.out_level)   bad = {bad, " out_level"};
         if (got.out_active  !== w.out_active)  bad = {bad, " out_active"};
         if (got.out_sensor  !== w.out_sensor)  bad = {bad, " out_sensor"};
         if (got.out_trigger !== w.out_trigger) bad = {bad, " out_trigger"};
         if (got.out_fired   !== w.out_fired)   bad = {bad, " out_fired"};
         if (got.last        !== w.last)        bad = {bad, " last"};
         if (bad != "") begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
               $display("mismatch on%s at %0t\n  expected %s\n  actual   %s",
                        bad, $realtime, show(w), show(got));
         end
      end
   endtask

   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin : receiver
      int stall;
      rsp_chan.ready <= 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (hold_request) begin
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 0;
         end
         stall = no_idle ? 0 : $urandom_range(0, GAP_MAX);
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
         check_outcome();
      end
   end

   initial begin : sender
      req_type r;
      int      phase;
      int      taken;
      int      n;
      for (n = 0; n < RULE_SLOTS; n++) begin
         rule_used[n]    = 1'b0;
         rule_sensor[n]  = '0;
         rule_target[n]  = '0;
         rule_trigger[n] = 1'b0;
         rule_action[n]  = 1'b0;
         rule_fired[n]   = 1'b0;
      end
      req_chan.valid <= 1'b0;
      put_req('0);

      plan.push_back(row(idx_req(OP_READ, 4'd0), 1'b1, want(ST_OK, 4'd0)));
      plan.push_back(row(idx_req(OP_READ, 4'd3), 1'b1, want(ST_OK, 4'd3)));
      plan.push_back(row(idx_req(OP_READ, 4'd15), 1'b1, want(ST_BAD_INDEX, 4'd0)));
      plan.push_back(row(idx_req(OP_REMOVE, 4'd4), 1'b1, want(ST_BAD_INDEX, 4'd0)));
      plan.push_back(row(idx_req(OP_REMOVE, 4'd2), 1'b1, want(ST_NOT_ACTIVE, 4'd2)));
      plan.push_back(row(add_req(8'h10, 8'h20, 1'b0, KIND_UNKNOWN, 1'b1, 1'b1), 1'b1,
                         want(ST_BAD_SENSOR, 4'd0)));
      plan.push_back(row(add_req(8'h10, 8'h20, 1'b1, KIND_UNKNOWN, 1'b1, 1'b1), 1'b1,
                         want(ST_BAD_TARGET, 4'd0)));
      plan.push_back(row(add_req(8'h10, 8'h20, 1'b1, KIND_OTHER, 1'b1, 1'b1), 1'b1,
                         want(ST_NOT_SWITCH, 4'd0)));
      plan.push_back(row(add_req(8'h00, 8'hFF, 1'b1, KIND_LIGHT, 1'b1, 1'b1), 1'b1,
                         want(ST_OK, 4'd0)));
      plan.push_back(row(add_req(8'hFF, 8'h00, 1'b1, KIND_RELAY, 1'b0, 1'b0), 1'b1,
                         want(ST_OK, 4'd1)));
      plan.push_back(row(add_req(8'hFF, 8'hA5, 1'b1, KIND_LIGHT, 1'b1, 1'b0), 1'b1,
                         want(ST_OK, 4'd2)));
      plan.push_back(row(add_req(8'hFF, 8'h5A, 1'b1, KIND_RELAY, 1'b1, 1'b1), 1'b1,
                         want(ST_OK, 4'd3)));
      plan.push_back(row(add_req(8'h77, 8'h77, 1'b1, KIND_LIGHT, 1'b0, 1'b1), 1'b1,
                         want(ST_NO_SLOT, 4'd0)));
      plan.push_back(row(reading_req(8'hFF, 1'b1, 16'd1), 1'b0, '0));
      plan.push_back(row(reading_req(8'hFF, 1'b1, 16'd1), 1'b0, '0));
      plan.push_back(row(reading_req(8'hFF, 1'b1, 16'd0), 1'b0, '0));
      plan.push_back(row(reading_req(8'hFF, 1'b1, 16'hFFFF), 1'b0, '0));
      plan.push_back(row(reading_req(8'hFF, 1'b0, 16'd1), 1'b0, '0));
      plan.push_back(row(idx_req(OP_READ, 4'd2), 1'b0, '0));
      plan.push_back(row(reading_req(8'hFF, 1'b1, 16'd1), 1'b0, '0));
      plan.push_back(row(idx_req(OP_READ, 4'd3), 1'b0, '0));
      plan.push_back(row(idx_req(OP_REMOVE, 4'd1), 1'b1, want(ST_OK, 4'd1)));
      plan.push_back(row(idx_req(OP_REMOVE, 4'd1), 1'b1, want(ST_NOT_ACTIVE, 4'd1)));
      plan.push_back(row(reading_req(8'h00, 1'b1, 16'd1), 1'b0, '0));
      plan.push_back(row(idx_req(OP_READ, 4'd0), 1'b0, '0));

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[i]) send_item(plan[i].item, plan[i].typed, plan[i].want);

      for (phase = 0; phase < 4; phase++) begin
         if (phase == 1) begin
            no_idle = 1;
         end else if (phase == 2) begin
            no_idle = 0;
            // let every pending result come back, then flood while the sink holds off
            drain_wait();
            hold_request = 1;
            burst_left   = BURST_ITEMS;
         end
         taken = 0;
         while (taken < PHASE_ITEMS) begin
            r = rand_req();
            send_item(r, 1'b0, '0);
            if (!(r.operation == OP_READING && !r.reading_valid)) taken++;
         end
      end

      req_chan.valid <= 1'b0;
      while (due_outcomes.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0 && due_outcomes.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

>>> sim.f
hdl/etrt_pkg.sv
hdl/etrt_if.sv
hdl/etrt_ctrl.sv
hdl/etrt_datapath.sv
hdl/edge_triggered_event_rule_table_core.sv
hdl/etrt_checker.sv
bench/edge_triggered_event_rule_table_core_tb.sv
